// ===== src/indentation_aware_tokenizer_core_macros.svh =====
// Assertion macros shared by the tokenizer RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef INDENTATION_AWARE_TOKENIZER_CORE_MACROS_SVH
`define INDENTATION_AWARE_TOKENIZER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define IATOK_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define IATOK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/iatok_pkg.sv =====
// Shared types, token kinds, character codes and keyword lookup for the tokenizer.
// Used by the controller, the datapath and the top level.
package iatok_pkg;

    localparam logic [4:0] KIND_BYTE     = 5'd0;
    localparam logic [4:0] KIND_EOF      = 5'd1;
    localparam logic [4:0] KIND_NEWLINE  = 5'd2;
    localparam logic [4:0] KIND_INDENT   = 5'd3;
    localparam logic [4:0] KIND_DEDENT   = 5'd4;
    localparam logic [4:0] KIND_LPAREN   = 5'd5;
    localparam logic [4:0] KIND_RPAREN   = 5'd6;
    localparam logic [4:0] KIND_PLUS     = 5'd7;
    localparam logic [4:0] KIND_STAR     = 5'd8;
    localparam logic [4:0] KIND_ASSIGN   = 5'd9;
    localparam logic [4:0] KIND_GT       = 5'd10;
    localparam logic [4:0] KIND_GTE      = 5'd11;
    localparam logic [4:0] KIND_INT      = 5'd12;
    localparam logic [4:0] KIND_IDENT    = 5'd13;
    localparam logic [4:0] KIND_STRING   = 5'd14;
    localparam logic [4:0] KIND_ERROR    = 5'd15;
    localparam logic [4:0] KIND_KEYWORD0 = 5'd16;

    localparam logic [7:0] ERR_CHAR    = 8'd0;
    localparam logic [7:0] ERR_UNTERM  = 8'd1;
    localparam logic [7:0] ERR_ESC_EOF = 8'd2;
    localparam logic [7:0] ERR_BAD_ESC = 8'd3;
    localparam logic [7:0] ERR_TAB     = 8'd4;
    localparam logic [7:0] ERR_STEP    = 8'd5;
    localparam logic [7:0] ERR_DEDENT  = 8'd6;
    localparam logic [7:0] ERR_FULL    = 8'd7;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_T  = 8'h74;

    localparam logic [4:0] MAX_RESULTS = 5'd20;
    localparam logic [3:0] STEP_RESET  = 4'd4;

    localparam int NUM_KEYWORDS = 12;
    localparam logic [47:0] KW_TEXT [NUM_KEYWORDS] = '{
        48'h000061746175, 48'h000062617275, 48'h000062696c6f, 48'h62756c69616e,
        48'h63616c69616b, 48'h000064617269, 48'h66756e677369, 48'h00696e64616b,
        48'h000000006a6f, 48'h73616d706169, 48'h73696d70616e, 48'h756e7475616b
    };
    localparam logic [2:0] KW_LEN [NUM_KEYWORDS] = '{
        3'd4, 3'd4, 3'd4, 3'd6, 3'd6, 3'd4, 3'd6, 3'd5, 3'd2, 3'd6, 3'd6, 3'd6
    };

    typedef enum logic [2:0] {
        OP_IDLE, OP_PRE, OP_ICMP, OP_POP, OP_DED, OP_BODY, OP_EOT, OP_FLUSH
    } t_op;

    typedef enum logic [1:0] {
        ROUTE_DONE, ROUTE_INDENT, ROUTE_BODY, ROUTE_EOT
    } t_route;

    typedef struct packed {
        t_op  op;
        logic go;
        logic accept;
    } t_dp_cmd;

    typedef struct packed {
        t_route route;
        logic   can_go;
        logic   pend_valid;
        logic   indent_lt;
        logic   pop_more;
        logic   npop_zero;
        logic   npop_one;
        logic   byte_zero;
        logic   eot_more;
    } t_dp_stat;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
            || (c == 8'h5F);
    endfunction

    function automatic logic [4:0] keyword_kind(input logic [47:0] buf_in,
                                                input logic [2:0] len);
        logic [4:0] k;
        k = KIND_IDENT;
        for (int i = 0; i < NUM_KEYWORDS; i++) begin
            if ((len == KW_LEN[i]) && (buf_in == KW_TEXT[i])) begin
                k = KIND_KEYWORD0 + 5'(i);
            end
        end
        return k;
    endfunction

endpackage

// ===== src/iatok_ctrl.sv =====
// Sequencing controller of the tokenizer: walks each accepted byte through its phases.
// Depends on iatok_pkg and the assertion macro header.
`include "indentation_aware_tokenizer_core_macros.svh"

module iatok_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  iatok_pkg::t_dp_stat i_stat,
    output iatok_pkg::t_dp_cmd  o_cmd
);
    import iatok_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_PRE, S_ICMP, S_POP, S_DED, S_BODY, S_EOT, S_FLUSH
    } t_state;

    t_state r_state, n_state;
    logic   r_ready;
    t_op    w_op;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid && r_ready) n_state = S_PRE;
            end
            S_PRE: begin
                if (i_stat.can_go) begin
                    case (i_stat.route)
                        ROUTE_INDENT: n_state = S_ICMP;
                        ROUTE_BODY:   n_state = S_BODY;
                        ROUTE_EOT:    n_state = S_EOT;
                        default:      n_state = S_FLUSH;
                    endcase
                end
            end
            S_ICMP: begin
                if (i_stat.can_go) n_state = i_stat.indent_lt ? S_POP : S_BODY;
            end
            S_POP: begin
                if (i_stat.can_go && !i_stat.pop_more) begin
                    n_state = i_stat.npop_zero ? S_BODY : S_DED;
                end
            end
            S_DED: begin
                if (i_stat.can_go && i_stat.npop_one) n_state = S_BODY;
            end
            S_BODY: begin
                if (i_stat.can_go) n_state = i_stat.byte_zero ? S_EOT : S_FLUSH;
            end
            S_EOT: begin
                if (i_stat.can_go && !i_stat.eot_more) n_state = S_FLUSH;
            end
            S_FLUSH: begin
                if (i_stat.can_go) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        case (r_state)
            S_PRE:   w_op = OP_PRE;
            S_ICMP:  w_op = OP_ICMP;
            S_POP:   w_op = OP_POP;
            S_DED:   w_op = OP_DED;
            S_BODY:  w_op = OP_BODY;
            S_EOT:   w_op = OP_EOT;
            S_FLUSH: w_op = OP_FLUSH;
            default: w_op = OP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

    assign o_ready      = r_ready;
    assign o_cmd.op     = w_op;
    assign o_cmd.go     = i_stat.can_go && (r_state != S_IDLE);
    assign o_cmd.accept = i_valid && r_ready;

    // Every result of a byte has left the holding slot before the next byte is taken.
    `IATOK_ASSERT_IMP(a_idle_no_pending, i_clk, i_rst_n, r_state == S_IDLE, !i_stat.pend_valid, "result still pending while idle")

endmodule

// ===== src/iatok_dp.sv =====
// Tokenizer datapath: scan state, position counters, indentation stack and result registers.
// Depends on iatok_pkg and the assertion macro header.
`include "indentation_aware_tokenizer_core_macros.svh"

module iatok_dp #(
    parameter int INDENT_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  iatok_pkg::t_dp_cmd  i_cmd,
    output iatok_pkg::t_dp_stat o_stat,
    input  logic [7:0]          i_source_byte,
    input  logic                i_cfg_we,
    input  logic [3:0]          i_cfg_data,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [4:0]          o_kind,
    output logic [7:0]          o_detail,
    output logic [15:0]         o_line_number,
    output logic [15:0]         o_column_number,
    output logic                o_last
);
    import iatok_pkg::*;

    localparam int DW = $clog2(INDENT_DEPTH + 1);
    localparam int IW = $clog2(INDENT_DEPTH);

    typedef enum logic [3:0] {
        M_LINE, M_LINECMT, M_BODY, M_CMT, M_INT, M_IDENT, M_GT, M_STR, M_ESC
    } t_mode;

    typedef struct packed {
        logic [4:0]  kind;
        logic [7:0]  detail;
        logic [15:0] line;
        logic [15:0] col;
    } t_result;

    t_mode         r_mode, n_mode;
    logic [7:0]    r_byte;
    logic [7:0]    r_lead, n_lead;
    logic [15:0]   r_line, n_line, r_col, n_col;
    logic [47:0]   r_buf, n_buf;
    logic [2:0]    r_len, n_len;
    logic [15:0]   r_oline, n_oline, r_ocol, n_ocol;
    logic [DW-1:0] r_depth, n_depth;
    logic [DW-1:0] r_npop, n_npop;
    logic [3:0]    r_step;
    logic [4:0]    r_rcount;
    logic [7:0]    r_levels [INDENT_DEPTH];

    logic          r_pend_valid, r_out_valid, r_out_last;
    t_result       r_pend, r_out, w_new;

    logic          w_emit, w_push;
    t_route        w_route;
    logic [7:0]    c;
    logic [15:0]   w_nline, w_ncol;
    logic [IW-1:0] w_top_idx;
    logic [7:0]    w_top, w_diff;
    logic          w_can_go, w_do_emit, w_load_out, w_flush;

    assign c         = r_byte;
    assign w_top_idx = IW'(r_depth - DW'(1));
    assign w_top     = (w_top_idx == '0) ? 8'd0 : r_levels[w_top_idx];
    assign w_diff    = r_lead - w_top;

    // Position after consuming the held byte.
    always_comb begin
        if (c == CH_LF) begin
            w_nline = (r_line != 16'hFFFF) ? r_line + 16'd1 : r_line;
            w_ncol  = 16'd1;
        end else begin
            w_nline = r_line;
            w_ncol  = (r_col != 16'hFFFF) ? r_col + 16'd1 : r_col;
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_lead   = r_lead;
        n_line   = r_line;
        n_col    = r_col;
        n_buf    = r_buf;
        n_len    = r_len;
        n_oline  = r_oline;
        n_ocol   = r_ocol;
        n_depth  = r_depth;
        n_npop   = r_npop;
        w_push   = 1'b0;
        w_emit   = 1'b0;
        w_route  = ROUTE_DONE;
        w_new.kind   = KIND_BYTE;
        w_new.detail = 8'd0;
        w_new.line   = r_line;
        w_new.col    = r_col;
        case (i_cmd.op)
            OP_PRE: begin
                case (r_mode)
                    M_LINE: begin
                        if (c == CH_SPACE) begin
                            n_col = w_ncol;
                            if (r_lead != 8'hFF) n_lead = r_lead + 8'd1;
                        end else if (c == CH_LF) begin
                            n_line = w_nline;
                            n_col  = w_ncol;
                            w_emit = 1'b1;
                            w_new.kind = KIND_NEWLINE;
                            w_new.line = w_nline;
                            w_new.col  = w_ncol;
                            n_lead = 8'd0;
                        end else if (c == CH_HASH) begin
                            n_col  = w_ncol;
                            n_mode = M_LINECMT;
                        end else if (c == CH_NUL) begin
                            w_route = ROUTE_EOT;
                        end else if (c == CH_TAB) begin
                            n_col  = w_ncol;
                            w_emit = 1'b1;
                            w_new.kind   = KIND_ERROR;
                            w_new.detail = ERR_TAB;
                            w_new.col    = w_ncol;
                            n_mode = M_BODY;
                        end else begin
                            w_route = ROUTE_INDENT;
                        end
                    end
                    M_LINECMT, M_CMT: begin
                        if (c == CH_NUL) begin
                            w_route = ROUTE_EOT;
                        end else begin
                            n_line = w_nline;
                            n_col  = w_ncol;
                            if (c == CH_LF) begin
                                w_emit = 1'b1;
                                w_new.kind = KIND_NEWLINE;
                                w_new.line = w_nline;
                                w_new.col  = w_ncol;
                                n_mode = M_LINE;
                                n_lead = 8'd0;
                            end
                        end
                    end
                    M_INT: begin
                        w_emit = 1'b1;
                        if (is_digit(c)) begin
                            n_col = w_ncol;
                            w_new.detail = c;
                            w_new.col    = w_ncol;
                        end else begin
                            w_new.kind = KIND_INT;
                            w_route    = ROUTE_BODY;
                        end
                    end
                    M_IDENT: begin
                        w_emit = 1'b1;
                        if (is_alpha(c) || is_digit(c)) begin
                            n_col = w_ncol;
                            w_new.detail = c;
                            w_new.col    = w_ncol;
                            if (r_len < 3'd6) n_buf = {r_buf[39:0], c};
                            if (r_len < 3'd7) n_len = r_len + 3'd1;
                        end else begin
                            w_new.kind = keyword_kind(r_buf, r_len);
                            w_route    = ROUTE_BODY;
                        end
                    end
                    M_GT: begin
                        w_emit = 1'b1;
                        if (c == CH_EQUAL) begin
                            n_col = w_ncol;
                            w_new.kind = KIND_GTE;
                            w_new.col  = w_ncol;
                            n_mode = M_BODY;
                        end else begin
                            w_new.kind = KIND_GT;
                            w_route    = ROUTE_BODY;
                        end
                    end
                    M_STR: begin
                        if (c == CH_NUL || c == CH_LF) begin
                            w_emit = 1'b1;
                            w_new.kind   = KIND_ERROR;
                            w_new.detail = ERR_UNTERM;
                            w_route = (c == CH_NUL) ? ROUTE_EOT : ROUTE_BODY;
                        end else begin
                            n_col = w_ncol;
                            w_new.line = r_oline;
                            w_new.col  = r_ocol;
                            if (c == CH_BSLASH) begin
                                n_mode = M_ESC;
                            end else if (c == CH_QUOTE) begin
                                w_emit = 1'b1;
                                w_new.kind = KIND_STRING;
                                n_mode = M_BODY;
                            end else begin
                                w_emit = 1'b1;
                                w_new.detail = c;
                            end
                        end
                    end
                    M_ESC: begin
                        w_emit = 1'b1;
                        if (c == CH_NUL) begin
                            w_new.kind   = KIND_ERROR;
                            w_new.detail = ERR_ESC_EOF;
                            w_route = ROUTE_EOT;
                        end else begin
                            n_col  = w_ncol;
                            n_mode = M_STR;
                            w_new.line = r_oline;
                            w_new.col  = r_ocol;
                            if (c == CH_LOW_N) begin
                                w_new.detail = CH_LF;
                            end else if (c == CH_LOW_T) begin
                                w_new.detail = CH_TAB;
                            end else if (c == CH_QUOTE || c == CH_BSLASH) begin
                                w_new.detail = c;
                            end else begin
                                w_new.kind   = KIND_ERROR;
                                w_new.detail = ERR_BAD_ESC;
                                w_new.line   = r_line;
                                w_new.col    = w_ncol;
                                n_mode = M_BODY;
                            end
                        end
                    end
                    default: w_route = ROUTE_BODY;
                endcase
            end
            OP_ICMP: begin
                n_npop = '0;
                if (r_lead > w_top) begin
                    w_emit = 1'b1;
                    if (w_diff != {4'd0, r_step}) begin
                        w_new.kind   = KIND_ERROR;
                        w_new.detail = ERR_STEP;
                    end else if (r_depth >= DW'(INDENT_DEPTH)) begin
                        w_new.kind   = KIND_ERROR;
                        w_new.detail = ERR_FULL;
                    end else begin
                        w_push  = 1'b1;
                        n_depth = r_depth + DW'(1);
                        w_new.kind = KIND_INDENT;
                    end
                end
            end
            OP_POP: begin
                if ((r_depth > DW'(1)) && (r_lead < w_top)) begin
                    n_depth = r_depth - DW'(1);
                    n_npop  = r_npop + DW'(1);
                end else if (r_lead != w_top) begin
                    w_emit = 1'b1;
                    w_new.kind   = KIND_ERROR;
                    w_new.detail = ERR_DEDENT;
                end
            end
            OP_DED: begin
                w_emit = 1'b1;
                w_new.kind = KIND_DEDENT;
                n_npop = r_npop - DW'(1);
            end
            OP_BODY: begin
                n_mode = M_BODY;
                if (c != CH_NUL) begin
                    n_line = w_nline;
                    n_col  = w_ncol;
                    w_new.line = w_nline;
                    w_new.col  = w_ncol;
                    if (c == CH_SPACE || c == CH_CR) begin
                        n_mode = M_BODY;
                    end else if (c == CH_HASH) begin
                        n_mode = M_CMT;
                    end else if (c == CH_LF) begin
                        w_emit = 1'b1;
                        w_new.kind = KIND_NEWLINE;
                        n_mode = M_LINE;
                        n_lead = 8'd0;
                    end else if (c == CH_QUOTE) begin
                        n_oline = w_nline;
                        n_ocol  = w_ncol;
                        n_mode  = M_STR;
                    end else if (is_digit(c)) begin
                        w_emit = 1'b1;
                        w_new.detail = c;
                        n_mode = M_INT;
                    end else if (is_alpha(c)) begin
                        w_emit = 1'b1;
                        w_new.detail = c;
                        n_buf  = {40'd0, c};
                        n_len  = 3'd1;
                        n_mode = M_IDENT;
                    end else if (c == CH_GT) begin
                        n_mode = M_GT;
                    end else begin
                        w_emit = 1'b1;
                        if (c == CH_LPAREN)      w_new.kind = KIND_LPAREN;
                        else if (c == CH_RPAREN) w_new.kind = KIND_RPAREN;
                        else if (c == CH_PLUS)   w_new.kind = KIND_PLUS;
                        else if (c == CH_STAR)   w_new.kind = KIND_STAR;
                        else if (c == CH_EQUAL)  w_new.kind = KIND_ASSIGN;
                        else begin
                            w_new.kind   = KIND_ERROR;
                            w_new.detail = ERR_CHAR;
                        end
                    end
                end
            end
            OP_EOT: begin
                w_emit = 1'b1;
                if (r_depth > DW'(1)) begin
                    n_depth = r_depth - DW'(1);
                    w_new.kind = KIND_DEDENT;
                end else begin
                    w_new.kind = KIND_EOF;
                    n_mode = M_LINE;
                    n_lead = 8'd0;
                end
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    // A result waits in the holding slot until the next one, or the end of the byte,
    // tells whether it is the last of its byte.
    assign w_can_go   = !r_pend_valid || !r_out_valid || i_ready;
    assign w_do_emit  = i_cmd.go && w_emit && (r_rcount < MAX_RESULTS);
    assign w_flush    = i_cmd.go && (i_cmd.op == OP_FLUSH) && r_pend_valid;
    assign w_load_out = (w_do_emit && r_pend_valid) || w_flush;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= M_LINE;
            r_lead       <= 8'd0;
            r_line       <= 16'd1;
            r_col        <= 16'd1;
            r_buf        <= 48'd0;
            r_len        <= 3'd0;
            r_oline      <= 16'd0;
            r_ocol       <= 16'd0;
            r_depth      <= DW'(1);
            r_npop       <= '0;
            r_step       <= STEP_RESET;
            r_rcount     <= 5'd0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) r_step <= i_cfg_data;
            if (i_cmd.accept) r_rcount <= 5'd0;
            if (i_cmd.go) begin
                r_mode  <= n_mode;
                r_lead  <= n_lead;
                r_line  <= n_line;
                r_col   <= n_col;
                r_buf   <= n_buf;
                r_len   <= n_len;
                r_oline <= n_oline;
                r_ocol  <= n_ocol;
                r_depth <= n_depth;
                r_npop  <= n_npop;
            end
            if (w_do_emit) begin
                r_rcount     <= r_rcount + 5'd1;
                r_pend_valid <= 1'b1;
            end else if (w_flush) begin
                r_pend_valid <= 1'b0;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_byte <= i_source_byte;
        if (i_cmd.go && w_push) r_levels[IW'(r_depth)] <= r_lead;
        if (w_do_emit) r_pend <= w_new;
        if (w_load_out) begin
            r_out      <= r_pend;
            r_out_last <= w_flush;
        end
    end

    assign o_stat.route      = w_route;
    assign o_stat.can_go     = w_can_go;
    assign o_stat.pend_valid = r_pend_valid;
    assign o_stat.indent_lt  = r_lead < w_top;
    assign o_stat.pop_more   = (r_depth > DW'(1)) && (r_lead < w_top);
    assign o_stat.npop_zero  = (r_npop == '0);
    assign o_stat.npop_one   = (r_npop == DW'(1));
    assign o_stat.byte_zero  = (r_byte == CH_NUL);
    assign o_stat.eot_more   = (r_depth > DW'(1));

    assign o_valid         = r_out_valid;
    assign o_kind          = r_out.kind;
    assign o_detail        = r_out.detail;
    assign o_line_number   = r_out.line;
    assign o_column_number = r_out.col;
    assign o_last          = r_out_last;

    `IATOK_ASSERT_IMP(a_depth_range, i_clk, i_rst_n, 1'b1, (r_depth != '0) && (r_depth <= DW'(INDENT_DEPTH)), "indentation depth out of range")
    `IATOK_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, i_cmd.go && w_push, r_depth == ($past(r_depth) + DW'(1)), "push did not grow the stack")
    `IATOK_ASSERT_IMP(a_result_limit, i_clk, i_rst_n, 1'b1, r_rcount <= MAX_RESULTS, "result count above limit")

endmodule

// ===== src/indentation_aware_tokenizer_core.sv =====
// Top level of the indentation-aware tokenizer: controller plus datapath.
// Depends on iatok_pkg, iatok_ctrl and iatok_dp.
//
// Source bytes enter one at a time on the i_valid/o_ready channel (byte 0 ends the text) and
// tokens leave on o_valid/i_ready, each with line, column and a last flag on the final
// result of its byte. The block works on one byte at a time: an accepted byte passes the
// pre-scan, the indentation compare, pop and dedent steps, the code scan, the end-of-text
// step and the flush as it needs them before the next ready. The result sequencer produces
// one result per cycle while the output is not stalled; a dedent run pops the levels, then
// emits one dedent per popped level, and end of text one per open level. indent_step is to
// be written through i_cfg_we/i_cfg_data while the block is idle; the block does not enforce it.
module indentation_aware_tokenizer_core #(
    parameter int INDENT_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_source_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_kind,
    output logic [7:0]  o_detail,
    output logic [15:0] o_line_number,
    output logic [15:0] o_column_number,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_data
);
    import iatok_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    iatok_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    iatok_dp #(
        .INDENT_DEPTH (INDENT_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_source_byte   (i_source_byte),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_kind          (o_kind),
        .o_detail        (o_detail),
        .o_line_number   (o_line_number),
        .o_column_number (o_column_number),
        .o_last          (o_last)
    );

endmodule
